@@ src/scam_pkg.sv @@
`timescale 1ns / 1ps
// scam_pkg: shared types, request and status codes, default parameter values
// for the segmented complex argmin block. No dependencies.
package scam_pkg;

    localparam int MAX_GROUPS_DEF  = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CFG_W   = 11;
    localparam int GROUP_W = 10;
    localparam int PART_W  = 32;
    localparam int POS_W   = 32;
    localparam int CNT_W   = 31;

    localparam logic [CFG_W-1:0] GROUP_COUNT_RST = 11'd1024;
    localparam logic [CNT_W-1:0] COUNTER_MAX     = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_NONE        = {POS_W{1'b1}};

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [GROUP_W-1:0]       group;
        logic signed [PART_W-1:0] real_part;
        logic signed [PART_W-1:0] imag_part;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] best_position;
        logic [1:0]              status;
    } out_item_t;

endpackage

@@ src/scam_slot_ram.sv @@
`timescale 1ns / 1ps
// scam_slot_ram: single-port-write, single-port-read slot memory with a
// registered read. Depends on nothing.
module scam_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 96
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/scam_update.sv @@
`timescale 1ns / 1ps
// scam_update: order-key conversion and lexicographic compare of a new element
// against a stored slot. Depends on scam_pkg.
module scam_update #(
    parameter int KEY_W = 32
) (
    input  logic                          old_valid,
    input  logic [scam_pkg::CNT_W-1:0]    old_pos,
    input  logic [KEY_W-1:0]              old_real,
    input  logic [KEY_W-1:0]              old_imag,
    input  logic signed [scam_pkg::PART_W-1:0] new_real_part,
    input  logic signed [scam_pkg::PART_W-1:0] new_imag_part,
    input  logic [scam_pkg::CNT_W-1:0]    elem_cnt,
    output logic                          take,
    output logic [KEY_W-1:0]              new_real,
    output logic [KEY_W-1:0]              new_imag,
    output logic [scam_pkg::CNT_W-1:0]    best_pos
);

    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    // flipping the sign bit makes two's complement order as unsigned
    assign new_real = new_real_part[KEY_W-1:0] ^ SIGN_FLIP;
    assign new_imag = new_imag_part[KEY_W-1:0] ^ SIGN_FLIP;

    assign take = !old_valid || (new_real < old_real) ||
                  ((new_real == old_real) && (new_imag < old_imag));

    assign best_pos = take ? elem_cnt : old_pos;

endmodule

@@ src/segmented_complex_argmin.sv @@
`timescale 1ns / 1ps
// segmented_complex_argmin: top level, request sequencer, counters and output
// register around the slot memory. Depends on scam_pkg, scam_slot_ram, scam_update.
//
//  port group   dir  handshake         payload
//  s_*          in   s_valid/s_ready   s_data   (scam_pkg::in_item_t)
//  m_*          out  m_valid/m_ready   m_data   (scam_pkg::out_item_t)
//  cfg_*        in   cfg_we            cfg_wdata (group_count)
//
// Update, read and no-op requests read memory when accepted, then compare
// and write back in S_LOOKUP, which waits until the output register is free.
// Clear empties slots 0 to min(group_count, MAX_GROUPS)-1, one slot per cycle.
// After reset a pass empties every slot; s_ready stays low until it ends.
// A stalled m_ready holds the finished result; one new request is still taken.
module segmented_complex_argmin #(
    parameter int MAX_GROUPS  = scam_pkg::MAX_GROUPS_DEF,
    parameter int VALUE_WIDTH = scam_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  scam_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output scam_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [scam_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int KEY_W   = (VALUE_WIDTH < scam_pkg::PART_W) ? VALUE_WIDTH : scam_pkg::PART_W;
    localparam int ADDR_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SPAN_W  = $clog2(MAX_GROUPS + 1);
    localparam int BOUND_W = (SPAN_W > scam_pkg::CFG_W) ? SPAN_W : scam_pkg::CFG_W;
    localparam int GX_W    = (ADDR_W > scam_pkg::GROUP_W) ? ADDR_W : scam_pkg::GROUP_W;
    localparam int ENTRY_W = 1 + scam_pkg::CNT_W + 2 * KEY_W;

    localparam logic [BOUND_W-1:0] MAX_BOUND = BOUND_W'(MAX_GROUPS);
    localparam logic [BOUND_W-1:0] LAST_SLOT = BOUND_W'(MAX_GROUPS - 1);

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_CLEAR  = 4'b0100,
        S_LOOKUP = 4'b1000
    } state_t;

    typedef struct packed {
        logic                       valid;
        logic [scam_pkg::CNT_W-1:0] pos;
        logic [KEY_W-1:0]           key_real;
        logic [KEY_W-1:0]           key_imag;
    } slot_t;

    state_t                     state_reg, state_next;
    logic [BOUND_W-1:0]         sweep_reg, sweep_next;
    logic [scam_pkg::CFG_W-1:0] group_count_reg, group_count_next;
    logic [scam_pkg::CNT_W-1:0] elem_cnt_reg, elem_cnt_next;
    scam_pkg::in_item_t         req_reg, req_next;
    logic                       m_valid_reg, m_valid_next;
    scam_pkg::out_item_t        m_data_reg, m_data_next;

    logic [BOUND_W-1:0] bound;
    logic [BOUND_W-1:0] gc_ext;
    logic [GX_W-1:0]    s_group_ext, r_group_ext;
    logic               in_range;
    logic               out_free;
    logic               accept;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    slot_t              wr_slot;
    slot_t              rd_slot;
    logic [ENTRY_W-1:0] rd_raw;

    logic                       take;
    logic [KEY_W-1:0]           new_real, new_imag;
    logic [scam_pkg::CNT_W-1:0] best_pos;

    assign gc_ext      = BOUND_W'(group_count_reg);
    assign bound       = (gc_ext < MAX_BOUND) ? gc_ext : MAX_BOUND;
    assign s_group_ext = GX_W'(s_data.group);
    assign r_group_ext = GX_W'(req_reg.group);
    assign in_range    = BOUND_W'(req_reg.group) < bound;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign rd_slot     = slot_t'(rd_raw);

    scam_slot_ram #(
        .DEPTH  (MAX_GROUPS),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_slot)),
        .rd_en   (accept),
        .rd_addr (s_group_ext[ADDR_W-1:0]),
        .rd_data (rd_raw)
    );

    scam_update #(
        .KEY_W (KEY_W)
    ) u_update (
        .old_valid     (rd_slot.valid),
        .old_pos       (rd_slot.pos),
        .old_real      (rd_slot.key_real),
        .old_imag      (rd_slot.key_imag),
        .new_real_part (req_reg.real_part),
        .new_imag_part (req_reg.imag_part),
        .elem_cnt      (elem_cnt_reg),
        .take          (take),
        .new_real      (new_real),
        .new_imag      (new_imag),
        .best_pos      (best_pos)
    );

    always_comb begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        group_count_next = cfg_we ? cfg_wdata : group_count_reg;
        elem_cnt_next    = elem_cnt_reg;
        req_next         = req_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        wr_en            = 1'b0;
        wr_addr          = sweep_reg[ADDR_W-1:0];
        wr_slot          = '0;

        case (state_reg)
            S_INIT: begin
                wr_en      = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_data;
                    sweep_next = '0;
                    state_next = (s_data.req_type == scam_pkg::REQ_CLEAR) ? S_CLEAR : S_LOOKUP;
                end
            end
            S_CLEAR: begin
                if (sweep_reg < bound) begin
                    wr_en      = 1'b1;
                    sweep_next = sweep_reg + 1'b1;
                end else if (out_free) begin
                    elem_cnt_next             = '0;
                    m_valid_next              = 1'b1;
                    m_data_next.best_position = scam_pkg::POS_NONE;
                    m_data_next.status        = scam_pkg::STATUS_OK;
                    state_next                = S_IDLE;
                end
            end
            S_LOOKUP: begin
                wr_addr = r_group_ext[ADDR_W-1:0];
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.best_position = scam_pkg::POS_NONE;
                    m_data_next.status        = scam_pkg::STATUS_OK;
                    state_next                = S_IDLE;
                    case (req_reg.req_type)
                        scam_pkg::REQ_UPDATE: begin
                            if (elem_cnt_reg == scam_pkg::COUNTER_MAX) begin
                                m_data_next.status = scam_pkg::STATUS_SAT;
                            end else if (!in_range) begin
                                m_data_next.status = scam_pkg::STATUS_RANGE;
                                elem_cnt_next      = elem_cnt_reg + 1'b1;
                            end else begin
                                wr_en            = take;
                                wr_slot.valid    = 1'b1;
                                wr_slot.pos      = elem_cnt_reg;
                                wr_slot.key_real = new_real;
                                wr_slot.key_imag = new_imag;
                                m_data_next.best_position = {1'b0, best_pos};
                                elem_cnt_next    = elem_cnt_reg + 1'b1;
                            end
                        end
                        scam_pkg::REQ_READ: begin
                            if (!in_range) begin
                                m_data_next.status = scam_pkg::STATUS_RANGE;
                            end else if (rd_slot.valid) begin
                                m_data_next.best_position = {1'b0, rd_slot.pos};
                            end
                        end
                        default: begin
                            // no-op: fixed empty result
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_INIT;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            sweep_reg       <= '0;
            group_count_reg <= scam_pkg::GROUP_COUNT_RST;
            elem_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            group_count_reg <= group_count_next;
            elem_cnt_reg    <= elem_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
